FILE: src/ttp_pkg.sv
`timescale 1ns / 1ps

package ttp_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int FORCE_BITS_DEF  = 16;

  localparam int PULSE_W    = 12;
  localparam int IDX_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [IDX_W-1:0]   LAST_INDEX_RST = 8'd200;
  localparam logic [PULSE_W-1:0] MIN_PULSE_RST  = 12'd1244;
  localparam logic [PULSE_W-1:0] MAX_PULSE_RST  = 12'd1752;

  localparam logic [CFG_IDX_W-1:0] CFG_LAST_INDEX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE  = 2'd2;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic valid;
    logic is_query;
    logic wr_ok;
    logic done;
  } ctl_t;

endpackage

FILE: src/ttp_ram.sv
`timescale 1ns / 1ps

module ttp_ram #(
  parameter int WIDTH = ttp_pkg::FORCE_BITS_DEF,
  parameter int DEPTH = ttp_pkg::TABLE_DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/ttp_probe.sv
`timescale 1ns / 1ps

module ttp_probe #(
  parameter int TABLE_DEPTH = ttp_pkg::TABLE_DEPTH_DEF,
  parameter int FORCE_BITS  = ttp_pkg::FORCE_BITS_DEF,
  localparam int IW = $clog2(TABLE_DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  ttp_pkg::ctl_t                in_ctl,
  input  logic signed [IW:0]           in_low,
  input  logic signed [IW:0]           in_high,
  input  logic [IW-1:0]                in_mid,
  input  logic [IW-1:0]                in_top,
  input  logic [IW-1:0]                in_widx,
  input  logic signed [FORCE_BITS-1:0] in_force,
  input  logic [ttp_pkg::PULSE_W-1:0]  in_epulse,
  output ttp_pkg::ctl_t                out_ctl,
  output logic signed [IW:0]           out_low,
  output logic signed [IW:0]           out_high,
  output logic [IW-1:0]                out_mid,
  output logic [IW-1:0]                out_top,
  output logic [IW-1:0]                out_widx,
  output logic signed [FORCE_BITS-1:0] out_force,
  output logic [ttp_pkg::PULSE_W-1:0]  out_epulse
);

  logic                         active;
  logic [IW:0]                  sum;
  logic [IW-1:0]                mid_calc;
  logic                         we;
  logic [FORCE_BITS-1:0]        ram_rdata;
  logic signed [FORCE_BITS-1:0] tab_force;

  ttp_pkg::ctl_t                b_ctl_r;
  logic                         b_act_r;
  logic signed [IW:0]           b_low_r;
  logic signed [IW:0]           b_high_r;
  logic [IW-1:0]                b_mid_r;
  logic [IW-1:0]                b_top_r;
  logic [IW-1:0]                b_widx_r;
  logic signed [FORCE_BITS-1:0] b_force_r;
  logic [ttp_pkg::PULSE_W-1:0]  b_epulse_r;

  ttp_pkg::ctl_t                ctl_nxt;
  logic signed [IW:0]           low_nxt;
  logic signed [IW:0]           high_nxt;
  logic signed [IW:0]           mid_ext;

  ttp_pkg::ctl_t                o_ctl_r;
  logic signed [IW:0]           o_low_r;
  logic signed [IW:0]           o_high_r;
  logic [IW-1:0]                o_mid_r;
  logic [IW-1:0]                o_top_r;
  logic [IW-1:0]                o_widx_r;
  logic signed [FORCE_BITS-1:0] o_force_r;
  logic [ttp_pkg::PULSE_W-1:0]  o_epulse_r;

  // low < high holds while the search is open, so both ends are in range
  assign active   = in_ctl.valid & in_ctl.is_query & ~in_ctl.done;
  assign sum      = {1'b0, in_low[IW-1:0]} + {1'b0, in_high[IW-1:0]};
  assign mid_calc = sum[IW:1];
  assign we       = adv & in_ctl.valid & ~in_ctl.is_query & in_ctl.wr_ok;

  ttp_ram #(
    .WIDTH(FORCE_BITS),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(in_widx),
    .wdata(in_force),
    .re   (adv),
    .raddr(mid_calc),
    .rdata(ram_rdata)
  );

  assign tab_force = signed'(ram_rdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_ctl_r <= '0;
      b_act_r <= 1'b0;
    end else if (adv) begin
      b_ctl_r <= in_ctl;
      b_act_r <= active;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_low_r    <= in_low;
      b_high_r   <= in_high;
      b_mid_r    <= active ? mid_calc : in_mid;
      b_top_r    <= in_top;
      b_widx_r   <= in_widx;
      b_force_r  <= in_force;
      b_epulse_r <= in_epulse;
    end
  end

  always_comb begin
    ctl_nxt  = b_ctl_r;
    low_nxt  = b_low_r;
    high_nxt = b_high_r;
    mid_ext  = signed'({1'b0, b_mid_r});
    if (b_act_r) begin
      if (b_force_r > tab_force) begin
        low_nxt = mid_ext + (IW+1)'(1);
      end else if (b_force_r < tab_force) begin
        high_nxt = mid_ext - (IW+1)'(1);
      end else begin
        ctl_nxt.done = 1'b1;
      end
      if (!(low_nxt < high_nxt)) begin
        ctl_nxt.done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_ctl_r <= '0;
    end else if (adv) begin
      o_ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_low_r    <= low_nxt;
      o_high_r   <= high_nxt;
      o_mid_r    <= b_mid_r;
      o_top_r    <= b_top_r;
      o_widx_r   <= b_widx_r;
      o_force_r  <= b_force_r;
      o_epulse_r <= b_epulse_r;
    end
  end

  assign out_ctl    = o_ctl_r;
  assign out_low    = o_low_r;
  assign out_high   = o_high_r;
  assign out_mid    = o_mid_r;
  assign out_top    = o_top_r;
  assign out_widx   = o_widx_r;
  assign out_force  = o_force_r;
  assign out_epulse = o_epulse_r;

endmodule

FILE: src/thrust_to_pulse_table_search.sv
`timescale 1ns / 1ps

// Thrust to pulse-width lookup over a calibration table.
// Input channel (in_valid/in_ready): kind 0 stores force_req and entry_pulse at
// entry_index and gives no result; kind 1 searches the table (0..last_index) for
// force_req and returns the clamped pulse width and the index it came from.
// Result channel (out_valid/out_ready) carries one item per query, in order.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
// write it only while no request is in flight.
// Every binary-search probe owns two stages and its own copy of the force
// table, so one request enters per cycle while the pipe is not held. Table
// writes travel down the same pipe and update each copy as they pass it,
// which keeps them ordered with the queries around them.
// Reset restores last_index 200, min_pulse 1244, max_pulse 1752 and empties the
// pipe; table contents are unknown until written.
// When out_ready is low with a result waiting, the whole pipe holds and in_ready
// drops; nothing is lost or repeated.
module thrust_to_pulse_table_search #(
  parameter int TABLE_DEPTH = ttp_pkg::TABLE_DEPTH_DEF,
  parameter int FORCE_BITS  = ttp_pkg::FORCE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_kind,
  input  logic [ttp_pkg::IDX_W-1:0]        in_entry_index,
  input  logic signed [FORCE_BITS-1:0]     in_force_req,
  input  logic [ttp_pkg::PULSE_W-1:0]      in_entry_pulse,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ttp_pkg::PULSE_W-1:0]      out_pulse_width,
  output logic [ttp_pkg::IDX_W-1:0]        out_chosen_index,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ttp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ttp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int IW     = $clog2(TABLE_DEPTH);
  localparam int PROBES = IW;
  localparam int WW     = IW + ttp_pkg::IDX_W;
  localparam int DW     = FORCE_BITS + 1;

  logic adv;

  logic [ttp_pkg::IDX_W-1:0]   last_index_r;
  logic [ttp_pkg::PULSE_W-1:0] min_pulse_r;
  logic [ttp_pkg::PULSE_W-1:0] max_pulse_r;

  // entry stage
  logic [WW-1:0]                ewide;
  logic [WW-1:0]                last_w;
  logic [WW-1:0]                top_w;
  logic [IW-1:0]                top_nxt;
  ttp_pkg::ctl_t                e_ctl_nxt;
  ttp_pkg::ctl_t                e_ctl_r;
  logic signed [IW:0]           e_high_r;
  logic [IW-1:0]                e_mid_r;
  logic [IW-1:0]                e_top_r;
  logic [IW-1:0]                e_widx_r;
  logic signed [FORCE_BITS-1:0] e_force_r;
  logic [ttp_pkg::PULSE_W-1:0]  e_epulse_r;

  ttp_pkg::ctl_t                st_ctl    [PROBES+1];
  logic signed [IW:0]           st_low    [PROBES+1];
  logic signed [IW:0]           st_high   [PROBES+1];
  logic [IW-1:0]                st_mid    [PROBES+1];
  logic [IW-1:0]                st_top    [PROBES+1];
  logic [IW-1:0]                st_widx   [PROBES+1];
  logic signed [FORCE_BITS-1:0] st_force  [PROBES+1];
  logic [ttp_pkg::PULSE_W-1:0]  st_epulse [PROBES+1];

  // neighbor read stage
  ttp_pkg::ctl_t                s_ctl;
  logic [IW-1:0]                s_mid;
  logic [IW-1:0]                lo_idx;
  logic [IW-1:0]                hi_idx;
  logic                         tab_we;
  logic [FORCE_BITS-1:0]        fm_raw;
  logic [FORCE_BITS-1:0]        fl_raw;
  logic [FORCE_BITS-1:0]        fh_raw;
  ttp_pkg::ctl_t                n_ctl_r;
  logic [IW-1:0]                n_mid_r;
  logic [IW-1:0]                n_lo_r;
  logic [IW-1:0]                n_hi_r;
  logic [IW-1:0]                n_widx_r;
  logic signed [FORCE_BITS-1:0] n_force_r;
  logic [ttp_pkg::PULSE_W-1:0]  n_epulse_r;

  // distance stage
  logic signed [DW-1:0]         dm_s;
  logic signed [DW-1:0]         dl_s;
  logic signed [DW-1:0]         dh_s;
  ttp_pkg::ctl_t                d_ctl_r;
  logic [DW-1:0]                d_dm_r;
  logic [DW-1:0]                d_dl_r;
  logic [DW-1:0]                d_dh_r;
  logic [IW-1:0]                d_mid_r;
  logic [IW-1:0]                d_lo_r;
  logic [IW-1:0]                d_hi_r;
  logic [IW-1:0]                d_widx_r;
  logic [ttp_pkg::PULSE_W-1:0]  d_epulse_r;

  // pick stage
  logic [IW-1:0]                pick_nxt;
  logic                         pw_we;
  logic [ttp_pkg::PULSE_W-1:0]  pw_raw;
  ttp_pkg::ctl_t                p_ctl_r;
  logic [IW-1:0]                p_pick_r;

  // result register
  logic [ttp_pkg::PULSE_W-1:0]  clamp_nxt;
  logic                         out_valid_r;
  logic [ttp_pkg::PULSE_W-1:0]  out_pulse_width_r;
  logic [ttp_pkg::IDX_W-1:0]    out_chosen_index_r;

  assign adv       = ~out_valid_r | out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_index_r <= ttp_pkg::LAST_INDEX_RST;
      min_pulse_r  <= ttp_pkg::MIN_PULSE_RST;
      max_pulse_r  <= ttp_pkg::MAX_PULSE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ttp_pkg::CFG_LAST_INDEX: last_index_r <= cfg_data[ttp_pkg::IDX_W-1:0];
        ttp_pkg::CFG_MIN_PULSE:  min_pulse_r  <= cfg_data[ttp_pkg::PULSE_W-1:0];
        ttp_pkg::CFG_MAX_PULSE:  max_pulse_r  <= cfg_data[ttp_pkg::PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- entry ----------------
  assign ewide   = WW'(in_entry_index);
  assign last_w  = WW'(last_index_r);
  assign top_w   = (last_w > WW'(TABLE_DEPTH - 1)) ? WW'(TABLE_DEPTH - 1) : last_w;
  assign top_nxt = top_w[IW-1:0];

  always_comb begin
    e_ctl_nxt          = '0;
    e_ctl_nxt.valid    = in_valid;
    e_ctl_nxt.is_query = (in_kind == ttp_pkg::KIND_QUERY);
    e_ctl_nxt.wr_ok    = (ewide < WW'(TABLE_DEPTH));
    e_ctl_nxt.done     = (top_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_ctl_r <= '0;
    end else if (adv) begin
      e_ctl_r <= e_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_high_r   <= signed'({1'b0, top_nxt});
      e_mid_r    <= top_nxt >> 1;
      e_top_r    <= top_nxt;
      e_widx_r   <= ewide[IW-1:0];
      e_force_r  <= in_force_req;
      e_epulse_r <= in_entry_pulse;
    end
  end

  assign st_ctl[0]    = e_ctl_r;
  assign st_low[0]    = '0;
  assign st_high[0]   = e_high_r;
  assign st_mid[0]    = e_mid_r;
  assign st_top[0]    = e_top_r;
  assign st_widx[0]   = e_widx_r;
  assign st_force[0]  = e_force_r;
  assign st_epulse[0] = e_epulse_r;

  // ---------------- search probes ----------------
  for (genvar k = 0; k < PROBES; k++) begin : g_probe
    ttp_probe #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .FORCE_BITS (FORCE_BITS)
    ) u_probe (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_ctl    (st_ctl[k]),
      .in_low    (st_low[k]),
      .in_high   (st_high[k]),
      .in_mid    (st_mid[k]),
      .in_top    (st_top[k]),
      .in_widx   (st_widx[k]),
      .in_force  (st_force[k]),
      .in_epulse (st_epulse[k]),
      .out_ctl   (st_ctl[k+1]),
      .out_low   (st_low[k+1]),
      .out_high  (st_high[k+1]),
      .out_mid   (st_mid[k+1]),
      .out_top   (st_top[k+1]),
      .out_widx  (st_widx[k+1]),
      .out_force (st_force[k+1]),
      .out_epulse(st_epulse[k+1])
    );
  end

  // ---------------- neighbor read ----------------
  assign s_ctl  = st_ctl[PROBES];
  assign s_mid  = st_mid[PROBES];
  assign lo_idx = (s_mid != '0) ? s_mid - IW'(1) : '0;
  assign hi_idx = (s_mid < st_top[PROBES]) ? s_mid + IW'(1) : st_top[PROBES];
  assign tab_we = adv & s_ctl.valid & ~s_ctl.is_query & s_ctl.wr_ok;

  ttp_ram #(.WIDTH(FORCE_BITS), .DEPTH(TABLE_DEPTH)) u_ram_fm (
    .clk  (clk),
    .we   (tab_we),
    .waddr(st_widx[PROBES]),
    .wdata(st_force[PROBES]),
    .re   (adv),
    .raddr(s_mid),
    .rdata(fm_raw)
  );

  ttp_ram #(.WIDTH(FORCE_BITS), .DEPTH(TABLE_DEPTH)) u_ram_fl (
    .clk  (clk),
    .we   (tab_we),
    .waddr(st_widx[PROBES]),
    .wdata(st_force[PROBES]),
    .re   (adv),
    .raddr(lo_idx),
    .rdata(fl_raw)
  );

  ttp_ram #(.WIDTH(FORCE_BITS), .DEPTH(TABLE_DEPTH)) u_ram_fh (
    .clk  (clk),
    .we   (tab_we),
    .waddr(st_widx[PROBES]),
    .wdata(st_force[PROBES]),
    .re   (adv),
    .raddr(hi_idx),
    .rdata(fh_raw)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_ctl_r <= '0;
    end else if (adv) begin
      n_ctl_r <= s_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_mid_r    <= s_mid;
      n_lo_r     <= lo_idx;
      n_hi_r     <= hi_idx;
      n_widx_r   <= st_widx[PROBES];
      n_force_r  <= st_force[PROBES];
      n_epulse_r <= st_epulse[PROBES];
    end
  end

  // ---------------- distances ----------------
  assign dm_s = signed'({n_force_r[FORCE_BITS-1], n_force_r})
              - signed'({fm_raw[FORCE_BITS-1], fm_raw});
  assign dl_s = signed'({n_force_r[FORCE_BITS-1], n_force_r})
              - signed'({fl_raw[FORCE_BITS-1], fl_raw});
  assign dh_s = signed'({n_force_r[FORCE_BITS-1], n_force_r})
              - signed'({fh_raw[FORCE_BITS-1], fh_raw});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_ctl_r <= '0;
    end else if (adv) begin
      d_ctl_r <= n_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_dm_r     <= dm_s[DW-1] ? DW'(-dm_s) : DW'(dm_s);
      d_dl_r     <= dl_s[DW-1] ? DW'(-dl_s) : DW'(dl_s);
      d_dh_r     <= dh_s[DW-1] ? DW'(-dh_s) : DW'(dh_s);
      d_mid_r    <= n_mid_r;
      d_lo_r     <= n_lo_r;
      d_hi_r     <= n_hi_r;
      d_widx_r   <= n_widx_r;
      d_epulse_r <= n_epulse_r;
    end
  end

  // ---------------- pick and pulse read ----------------
  // lower neighbor wins first, mid keeps ties
  always_comb begin
    if (d_dm_r > d_dl_r) begin
      pick_nxt = d_lo_r;
    end else if (d_dm_r > d_dh_r) begin
      pick_nxt = d_hi_r;
    end else begin
      pick_nxt = d_mid_r;
    end
  end

  assign pw_we = adv & d_ctl_r.valid & ~d_ctl_r.is_query & d_ctl_r.wr_ok;

  ttp_ram #(.WIDTH(ttp_pkg::PULSE_W), .DEPTH(TABLE_DEPTH)) u_ram_pw (
    .clk  (clk),
    .we   (pw_we),
    .waddr(d_widx_r),
    .wdata(d_epulse_r),
    .re   (adv),
    .raddr(pick_nxt),
    .rdata(pw_raw)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_ctl_r <= '0;
    end else if (adv) begin
      p_ctl_r <= d_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_pick_r <= pick_nxt;
    end
  end

  // ---------------- clamp and result ----------------
  // max test first, so it wins when the limits cross
  always_comb begin
    if (pw_raw > max_pulse_r) begin
      clamp_nxt = max_pulse_r;
    end else if (pw_raw < min_pulse_r) begin
      clamp_nxt = min_pulse_r;
    end else begin
      clamp_nxt = pw_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= p_ctl_r.valid & p_ctl_r.is_query;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pulse_width_r  <= clamp_nxt;
      out_chosen_index_r <= ttp_pkg::IDX_W'(p_pick_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pulse_width  = out_pulse_width_r;
  assign out_chosen_index = out_chosen_index_r;

endmodule

FILE: dv/thrust_to_pulse_table_search_tb.sv
`timescale 1ns / 1ps

module thrust_to_pulse_table_search_tb;
  import ttp_pkg::*;

  localparam int FW       = FORCE_BITS_DEF;
  localparam int DEPTH    = TABLE_DEPTH_DEF;
  localparam int PIPE_LAT = 21;

  typedef logic signed [FW-1:0] force_t;

  typedef struct {
    logic [PULSE_W-1:0] pulse;
    logic [IDX_W-1:0]   index;
  } pulse_pick_t;

  class pulse_table_checker;
    force_t              force_tab[DEPTH];
    logic [PULSE_W-1:0]  pulse_tab[DEPTH];
    bit                  written[DEPTH];
    logic [IDX_W-1:0]    last_idx;
    logic [PULSE_W-1:0]  min_clamp;
    logic [PULSE_W-1:0]  max_clamp;
    pulse_pick_t         pulses_due[$];
    int                  errors;

    function new();
      last_idx  = LAST_INDEX_RST;
      min_clamp = MIN_PULSE_RST;
      max_clamp = MAX_PULSE_RST;
      errors    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] reg_idx, logic [CFG_DATA_W-1:0] data);
      case (reg_idx)
        CFG_LAST_INDEX: last_idx = data[IDX_W-1:0];
        CFG_MIN_PULSE:  min_clamp = data[PULSE_W-1:0];
        CFG_MAX_PULSE:  max_clamp = data[PULSE_W-1:0];
        default: ;
      endcase
    endfunction

    function longint distance(force_t f, int k);
      longint d;
      d = longint'(f) - longint'(force_tab[k]);
      return (d < 0) ? -d : d;
    endfunction

    // Returns 0 with the first unwritten entry in miss if the search would read one.
    function bit find_pick(input force_t f, output logic [IDX_W-1:0] pick, output int miss);
      int top, lo, hi, mid, lo_n, hi_n;
      longint dm, dl, dh;
      pick = '0;
      miss = -1;
      top  = last_idx;
      lo   = 0;
      hi   = top;
      mid  = top / 2;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (!written[mid]) begin
          miss = mid;
          return 0;
        end
        if (f > force_tab[mid]) lo = mid + 1;
        else if (f < force_tab[mid]) hi = mid - 1;
        else break;
      end
      // hold neighbors inside the table ends
      lo_n = (mid > 0) ? mid - 1 : 0;
      hi_n = (mid < top) ? mid + 1 : top;
      if (!written[lo_n]) miss = lo_n;
      else if (!written[mid]) miss = mid;
      else if (!written[hi_n]) miss = hi_n;
      if (miss >= 0) return 0;
      dm = distance(f, mid);
      dl = distance(f, lo_n);
      dh = distance(f, hi_n);
      if (dm > dl) pick = lo_n[IDX_W-1:0];
      else if (dm > dh) pick = hi_n[IDX_W-1:0];
      else pick = mid[IDX_W-1:0];
      return 1;
    endfunction

    function void take_request(logic kind, logic [IDX_W-1:0] idx, force_t f,
                               logic [PULSE_W-1:0] entry_pulse);
      logic [IDX_W-1:0]   pick;
      logic [PULSE_W-1:0] pw;
      pulse_pick_t        due;
      int                 miss;
      if (kind == KIND_WRITE) begin
        force_tab[idx] = f;
        pulse_tab[idx] = entry_pulse;
        written[idx]   = 1'b1;
      end else begin
        void'(find_pick(f, pick, miss));
        pw = pulse_tab[pick];
        // max test wins when the clamps cross
        if (pw > max_clamp) pw = max_clamp;
        else if (pw < min_clamp) pw = min_clamp;
        due.pulse = pw;
        due.index = pick;
        pulses_due.push_back(due);
      end
    endfunction

    function void check_pulse(logic [PULSE_W-1:0] pw, logic [IDX_W-1:0] ci);
      pulse_pick_t due;
      if (pulses_due.size() == 0) begin
        $display({"%0t: result with no query waiting: expected none, ",
                  "actual pulse_width %0d chosen_index %0d"}, $time, pw, ci);
        errors++;
        return;
      end
      due = pulses_due.pop_front();
      if (pw !== due.pulse) begin
        $display("%0t: pulse_width expected %0d, actual %0d", $time, due.pulse, pw);
        errors++;
      end
      if (ci !== due.index) begin
        $display("%0t: chosen_index expected %0d, actual %0d", $time, due.index, ci);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_kind;
  logic [IDX_W-1:0]      in_entry_index;
  force_t                in_force_req;
  logic [PULSE_W-1:0]    in_entry_pulse;
  logic                  out_valid;
  logic                  out_ready;
  logic [PULSE_W-1:0]    out_pulse_width;
  logic [IDX_W-1:0]      out_chosen_index;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pulse_table_checker chk = new();

  bit tx_burst;
  int tx_rush;
  bit rx_burst;
  int rx_long_hold;

  thrust_to_pulse_table_search DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_entry_index   (in_entry_index),
    .in_force_req     (in_force_req),
    .in_entry_pulse   (in_entry_pulse),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pulse_width  (out_pulse_width),
    .out_chosen_index (out_chosen_index),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("** thrust_to_pulse_table_search: FAILED **");
    $finish;
  end

  function automatic force_t sat_force(int v);
    if (v > 32767) return force_t'(32767);
    if (v < -32768) return force_t'(-32768);
    return force_t'(v);
  endfunction

  task automatic send_req(logic kind, logic [IDX_W-1:0] idx, force_t f,
                          logic [PULSE_W-1:0] entry_pulse);
    int gap;
    gap = (tx_burst || tx_rush > 0) ? 0 : $urandom_range(0, 19);
    if (tx_rush > 0) tx_rush--;
    if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_entry_index <= idx;
    in_force_req   <= f;
    in_entry_pulse <= entry_pulse;
    do @(posedge clk); while (!in_ready);
    chk.take_request(kind, idx, f, entry_pulse);
  endtask

  // Send a query, or fill the entry it would read if that was never written.
  task automatic ask_force(force_t f);
    logic [IDX_W-1:0] pick;
    int miss;
    if (chk.find_pick(f, pick, miss))
      send_req(KIND_QUERY, IDX_W'($urandom_range(0, 255)), f, PULSE_W'($urandom_range(0, 4095)));
    else
      send_req(KIND_WRITE, IDX_W'(miss), force_t'($urandom), PULSE_W'($urandom_range(0, 4095)));
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (chk.pulses_due.size() != 0) @(posedge clk);
    // table writes give no result; let them clear the pipe
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic set_config(int li, int mn, int mx);
    logic [CFG_IDX_W-1:0]  regs[3];
    logic [CFG_DATA_W-1:0] vals[3];
    regs = '{CFG_LAST_INDEX, CFG_MIN_PULSE, CFG_MAX_PULSE};
    vals = '{CFG_DATA_W'(li), CFG_DATA_W'(mn), CFG_DATA_W'(mx)};
    for (int r = 0; r < 3; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[r];
      cfg_data  <= vals[r];
      do @(posedge clk); while (!cfg_ready);
      chk.set_reg(regs[r], vals[r]);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin : result_sink
    int gap;
    int hold;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_long_hold > 0) begin
        hold = rx_long_hold;
        rx_long_hold = 0;
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      gap = rx_burst ? 0 : $urandom_range(0, 19);
      if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      chk.check_pulse(out_pulse_width, out_chosen_index);
    end
  end

  initial begin : stimulus
    int ph_li[7];
    int ph_min[7];
    int ph_max[7];
    int ph_q[7];
    bit ph_load[7];
    int li, cur, span, sel, k;
    force_t f;

    ph_li   = '{255, 200, 1, 7, 31, 15, 0};
    ph_min  = '{0, 1244, 4095, 1000, 0, 4095, 0};
    ph_max  = '{4095, 1752, 0, 3000, 0, 4095, 0};
    ph_q    = '{60, 50, 35, 35, 35, 35, 40};
    ph_load = '{1, 0, 1, 1, 1, 1, 1};

    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_kind        <= KIND_WRITE;
    in_entry_index <= '0;
    in_force_req   <= '0;
    in_entry_pulse <= '0;
    cfg_valid      <= 1'b0;
    cfg_index      <= CFG_LAST_INDEX;
    cfg_data       <= '0;
    tx_burst       = 1'b0;
    tx_rush        = 0;
    rx_burst       = 1'b0;
    rx_long_hold   = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: four-entry table at the force extremes, no clamping
    set_config(3, 0, 4095);
    send_req(KIND_WRITE, 8'd0, sat_force(-32768), 12'd0);
    send_req(KIND_WRITE, 8'd1, sat_force(-1), 12'd4095);
    send_req(KIND_WRITE, 8'd2, sat_force(0), 12'd2048);
    send_req(KIND_WRITE, 8'd3, sat_force(32767), 12'h555);
    send_req(KIND_WRITE, 8'd255, sat_force(21845), 12'hAAA);
    ask_force(sat_force(-32768));
    ask_force(sat_force(32767));
    ask_force(sat_force(0));
    ask_force(sat_force(-1));
    ask_force(sat_force(-16384));
    ask_force(sat_force(16384));
    // equal distance to mid and upper neighbor: mid wins
    send_req(KIND_WRITE, 8'd3, sat_force(100), 12'h0F0);
    ask_force(sat_force(50));
    // duplicate forces, search stops on an exact hit
    send_req(KIND_WRITE, 8'd1, sat_force(0), 12'h70F);
    ask_force(sat_force(0));
    // last_index zero: only entry 0 is ever chosen
    drain_pipe();
    set_config(0, 100, 200);
    ask_force(sat_force(1234));
    ask_force(sat_force(-32768));

    ph_li[6]  = $urandom_range(2, 40);
    ph_min[6] = $urandom_range(0, 4095);
    ph_max[6] = $urandom_range(0, 4095);

    for (int ph = 0; ph < 7; ph++) begin
      li = ph_li[ph];
      drain_pipe();
      set_config(li, ph_min[ph], ph_max[ph]);
      if (ph_load[ph]) begin
        // ascending forces with random steps, some repeated
        cur  = -32768 + int'($urandom_range(0, 255));
        span = 131072 / (li + 1);
        for (int e = 0; e <= li; e++) begin
          send_req(KIND_WRITE, IDX_W'(e), sat_force(cur), PULSE_W'($urandom_range(0, 4095)));
          if ($urandom_range(0, 9) != 0) cur += int'($urandom_range(0, span - 1));
        end
      end
      if (ph == 1) begin
        // stall the result side while requests keep coming back to back
        rx_long_hold = 150;
        tx_rush      = 40;
      end
      for (int q = 0; q < ph_q[ph]; q++) begin
        if ($urandom_range(0, 24) < 2) begin
          send_req(KIND_WRITE, IDX_W'($urandom_range(0, 255)), force_t'($urandom),
                   PULSE_W'($urandom_range(0, 4095)));
        end else begin
          sel = $urandom_range(0, 9);
          k   = $urandom_range(0, li);
          if (sel < 5)
            f = sat_force(int'(chk.force_tab[k]) + int'($urandom_range(0, 16)) - 8);
          else if (sel < 7 && k < li)
            f = sat_force((int'(chk.force_tab[k]) + int'(chk.force_tab[k + 1])) / 2);
          else if (sel < 8)
            f = ($urandom_range(0, 1) == 1) ? sat_force(32767) : sat_force(-32768);
          else
            f = force_t'($urandom);
          ask_force(f);
        end
      end
    end

    drain_pipe();
    if (chk.errors == 0)
      $display("** thrust_to_pulse_table_search: PASSED **");
    else
      $display("** thrust_to_pulse_table_search: FAILED **");
    $finish;
  end

endmodule
